// ===== rtl/core/wed_pkg.sv =====
// shared types and constants for the weighted euclidean distance block
`default_nettype none

package wed_pkg;

   localparam int FIELD_BITS    = 16;
   localparam int DISTANCE_BITS = 64;
   localparam int ROOT_BITS     = DISTANCE_BITS / 2;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic MODE_SQUARED   = 1'b0;
   localparam logic MODE_EUCLIDEAN = 1'b1;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] first_value;
      logic signed [FIELD_BITS-1:0] second_value;
      logic        [FIELD_BITS-1:0] weight;
      logic                         last;
   } wed_req_type;

   typedef struct packed {
      logic [DISTANCE_BITS-1:0] distance;
      logic                     saturated;
   } wed_rsp_type;

   // one finished vector handed from the front to the back
   typedef struct packed {
      logic [DISTANCE_BITS-1:0] sum;
      logic                     saturated;
      logic                     mode;
   } wed_entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/wed_front.sv =====
// front pipeline: difference, square, weighting and saturating accumulation
`default_nettype none

module wed_front #(
   parameter int VALUE_BITS  = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire wed_pkg::wed_req_type  req_data,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_data,
   input  wire logic                  q_full,
   output logic                       push,
   output wed_pkg::wed_entry_type     entry
);

   localparam int EXT_BITS  = 2 * wed_pkg::FIELD_BITS;
   localparam int DIFF_BITS = VALUE_BITS + 1;
   localparam int SQ_BITS   = 2 * VALUE_BITS;
   localparam int TERM_BITS = SQ_BITS + WEIGHT_BITS;
   localparam int ACC_BITS  = wed_pkg::DISTANCE_BITS;

   logic [EXT_BITS-1:0]    first_ext;
   logic [EXT_BITS-1:0]    second_ext;
   logic [VALUE_BITS-1:0]  first_raw;
   logic [VALUE_BITS-1:0]  second_raw;
   logic [DIFF_BITS-1:0]   diff;
   logic [DIFF_BITS-1:0]   diff_abs;
   logic                   advance;

   logic                   mode_ff;
   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                   s1_last_ff, s2_last_ff, s3_last_ff;
   logic [VALUE_BITS-1:0]  s1_mag_ff, s1_mag_in;
   logic [WEIGHT_BITS-1:0] s1_weight_ff, s2_weight_ff;
   logic [SQ_BITS-1:0]     s2_sq_ff;
   logic [TERM_BITS-1:0]   s3_term_ff;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic                   over_ff, over_in;

   logic [ACC_BITS:0]      sum_wide;
   logic [ACC_BITS-1:0]    sum_sat;
   logic                   sum_over;

   always_comb begin
      first_ext  = {{(EXT_BITS-wed_pkg::FIELD_BITS){1'b0}}, req_data.first_value};
      second_ext = {{(EXT_BITS-wed_pkg::FIELD_BITS){1'b0}}, req_data.second_value};
      first_raw  = first_ext[VALUE_BITS-1:0];
      second_raw = second_ext[VALUE_BITS-1:0];
      diff       = {first_raw[VALUE_BITS-1], first_raw} - {second_raw[VALUE_BITS-1], second_raw};
      diff_abs   = diff[DIFF_BITS-1] ? (~diff + DIFF_BITS'(1)) : diff;
      s1_mag_in  = diff_abs[VALUE_BITS-1:0];
   end

   // a finished vector waits in the last stage while the queue is full
   assign advance   = !(s3_valid_ff && s3_last_ff && q_full);
   assign req_ready = advance;

   always_comb begin
      sum_wide = {1'b0, acc_ff} + {{(ACC_BITS+1-TERM_BITS){1'b0}}, s3_term_ff};
      sum_over = sum_wide[ACC_BITS];
      sum_sat  = sum_over ? {ACC_BITS{1'b1}} : sum_wide[ACC_BITS-1:0];

      acc_in          = acc_ff;
      over_in         = over_ff;
      push            = 1'b0;
      entry.sum       = sum_sat;
      entry.saturated = over_ff | sum_over;
      entry.mode      = mode_ff;
      if (advance && s3_valid_ff) begin
         if (s3_last_ff) begin
            push    = 1'b1;
            acc_in  = '0;
            over_in = 1'b0;
         end else begin
            acc_in  = sum_sat;
            over_in = over_ff | sum_over;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= wed_pkg::MODE_SQUARED;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         acc_ff      <= '0;
         over_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
         if (advance) begin
            s1_valid_ff <= req_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         acc_ff  <= acc_in;
         over_ff <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mag_ff    <= s1_mag_in;
         s1_weight_ff <= req_data.weight[WEIGHT_BITS-1:0];
         s1_last_ff   <= req_data.last;
         s2_sq_ff     <= s1_mag_ff * s1_mag_ff;
         s2_weight_ff <= s1_weight_ff;
         s2_last_ff   <= s1_last_ff;
         s3_term_ff   <= s2_sq_ff * s2_weight_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/wed_queue.sv =====
// short queue of finished vector sums between front and back
`default_nettype none

module wed_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire wed_pkg::wed_entry_type  push_data,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         not_empty,
   output wed_pkg::wed_entry_type       head
);

   localparam int DEPTH     = wed_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   wed_pkg::wed_entry_type slots_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/wed_back.sv =====
// back end: bit-serial integer square root and the result register
`default_nettype none

module wed_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_not_empty,
   input  wire wed_pkg::wed_entry_type  q_head,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output wed_pkg::wed_rsp_type         rsp_data
);

   localparam int DIST_BITS = wed_pkg::DISTANCE_BITS;
   localparam int ROOT_BITS = wed_pkg::ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int STEP_BITS = $clog2(ROOT_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [DIST_BITS-1:0] x_ff, x_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 sat_ff, sat_in;
   logic                 out_valid_ff, out_valid_in;
   wed_pkg::wed_rsp_type out_data_ff, out_data_in;

   logic                 out_free;
   logic [REM_BITS:0]    rem_shift;
   logic [REM_BITS:0]    trial;
   logic                 take;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      // one result bit per cycle, two radicand bits brought down
      rem_shift = {rem_ff[REM_BITS-2:0], x_ff[DIST_BITS-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      take      = (rem_shift >= trial);

      state_in     = state_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      sat_in       = sat_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               if (q_head.mode == wed_pkg::MODE_EUCLIDEAN) begin
                  q_pop    = 1'b1;
                  x_in     = q_head.sum;
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = '0;
                  sat_in   = q_head.saturated;
                  state_in = ST_ROOT;
               end else if (out_free) begin
                  q_pop                 = 1'b1;
                  out_valid_in          = 1'b1;
                  out_data_in.distance  = q_head.sum;
                  out_data_in.saturated = q_head.saturated;
               end
            end
         end
         ST_ROOT: begin
            rem_in  = take ? REM_BITS'(rem_shift - trial) : rem_shift[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], take};
            x_in    = {x_ff[DIST_BITS-3:0], 2'b00};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_data_in.distance  = {{(DIST_BITS-ROOT_BITS){1'b0}}, root_ff};
               out_data_in.saturated = sat_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      sat_ff      <= sat_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/weighted_euclidean_distance.sv =====
// top level: weighted squared or euclidean distance over streamed element pairs
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   wed_req_type (one element pair)
//   rsp       out         rsp_valid / rsp_ready   wed_rsp_type (one per vector)
//   csr       in          csr_valid / csr_ready   distance mode bit
//
// the front takes one element per cycle unless req_ready is low: three registered
// stages (difference, square, weight multiply) feed a 64-bit saturating accumulator.
// squared mode: a finished sum goes from the third stage through the queue to the
// result register that drives rsp_valid, when nothing waits ahead of it.
// euclidean mode: the shared bit-serial root unit computes the 32-bit root bit by bit.
// a two-entry queue holds finished vectors; req stalls only when a last element
// finds it full. synchronous reset clears the accumulator, mode and all valids.
`default_nettype none

module weighted_euclidean_distance #(
   parameter int VALUE_BITS  = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire wed_pkg::wed_req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output wed_pkg::wed_rsp_type       rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_data
);

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_not_empty;
   wed_pkg::wed_entry_type q_push_data;
   wed_pkg::wed_entry_type q_head;

   assign csr_ready = 1'b1;

   wed_front #(
      .VALUE_BITS  (VALUE_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .push      (q_push),
      .entry     (q_push_data)
   );

   wed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   wed_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for weighted_euclidean_distance: scoreboard, drivers and test sequence
`default_nettype none

module tb_top;

   localparam int SETTLE_CYCLES  = 100;
   localparam int TIMEOUT_CYCLES = 3_000_000;
   localparam int RANDOM_ITEMS   = 1300;

   class distance_scoreboard;
      wed_pkg::wed_rsp_type expected_distances[$];
      logic [63:0]          running_sum;
      bit                   overflow_flag;
      logic                 distance_mode;
      int                   mismatches;
      int                   results_checked;
      int                   saturated_results;

      function new();
         running_sum       = '0;
         overflow_flag     = 1'b0;
         distance_mode     = wed_pkg::MODE_SQUARED;
         mismatches        = 0;
         results_checked   = 0;
         saturated_results = 0;
      endfunction

      // bit-by-bit search for the largest root whose square fits
      static function logic [63:0] floor_root(input logic [63:0] x);
         logic [63:0] root;
         logic [63:0] trial;
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
         end
         return root;
      endfunction

      function int pending();
         return expected_distances.size();
      endfunction

      function void accumulate_element(input wed_pkg::wed_req_type item);
         longint               diff;
         logic [63:0]          magnitude;
         logic [64:0]          total;
         wed_pkg::wed_rsp_type outcome;
         diff = longint'($signed(item.first_value)) - longint'($signed(item.second_value));
         magnitude = (diff < 0) ? 64'(-diff) : 64'(diff);
         total = {1'b0, running_sum} + {1'b0, magnitude * magnitude * {48'd0, item.weight}};
         // carry out of the 64-bit sum means saturation
         if (total[64]) begin
            running_sum   = '1;
            overflow_flag = 1'b1;
         end else begin
            running_sum = total[63:0];
         end
         if (item.last) begin
            outcome.distance  = (distance_mode == wed_pkg::MODE_EUCLIDEAN) ?
                                floor_root(running_sum) : running_sum;
            outcome.saturated = overflow_flag;
            expected_distances.push_back(outcome);
            running_sum   = '0;
            overflow_flag = 1'b0;
         end
      endfunction

      function void note_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
      endfunction

      function void check_distance(input wed_pkg::wed_rsp_type seen);
         wed_pkg::wed_rsp_type want;
         if (expected_distances.size() == 0) begin
            note_mismatch("result with nothing pending", '0, seen.distance);
            return;
         end
         want = expected_distances.pop_front();
         results_checked++;
         if (want.saturated) saturated_results++;
         if (seen.distance !== want.distance)
            note_mismatch("distance", want.distance, seen.distance);
         if (seen.saturated !== want.saturated)
            note_mismatch("saturated flag", 64'(want.saturated), 64'(seen.saturated));
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   wed_pkg::wed_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   wed_pkg::wed_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_data  = 1'b0;

   distance_scoreboard board = new();
   bit quiet       = 1'b0;
   int elements_sent = 0;
   int mode_writes = 0;
   int ready_left  = 0;
   int stall_left  = 0;

   weighted_euclidean_distance u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      #(2 * TIMEOUT_CYCLES);
      $display("timeout with %0d results outstanding", board.pending());
      $display("Verification failed");
      $finish;
   end

   // mostly short gaps, a few long ones, none at all in quiet phases
   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic wed_pkg::wed_req_type make_item(input int a, input int b, input int w,
                                                     input bit last);
      wed_pkg::wed_req_type item;
      item.first_value  = a[15:0];
      item.second_value = b[15:0];
      item.weight       = w[15:0];
      item.last         = last;
      return item;
   endfunction

   function automatic int random_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
         endcase
      end
      if (roll < 60) return int'($urandom_range(0, 65535));
      return $urandom_range(0, 1024) - 512;
   endfunction

   function automatic int random_weight();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 0;
      if (roll < 20) return 65535;
      if (roll < 40) return $urandom_range(1, 256);
      return $urandom_range(0, 65535);
   endfunction

   // response side: random ready with stalls, checks every transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_distance(rsp_data);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (ready_left > 0) begin
            ready_left--;
         end else begin
            ready_left = $urandom_range(0, 12);
            stall_left = pick_gap();
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_element(input wed_pkg::wed_req_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.accumulate_element(item);
      elements_sent++;
   endtask

   task automatic idle_until_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      idle_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.distance_mode = mode;
      mode_writes++;
   endtask

   initial begin
      int vector_len;
      int random_sent;
      int phase;
      int phase_len;
      int phase_sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // squared mode straight from reset
      send_element(make_item(32767, -32768, 65535, 1'b1), pick_gap());
      send_element(make_item(-32768, 32767, 65535, 1'b1), pick_gap());
      send_element(make_item(0, 0, 65535, 1'b1), pick_gap());
      send_element(make_item(-32768, -32768, 0, 1'b1), pick_gap());
      send_element(make_item(1, 0, 1, 1'b1), pick_gap());
      send_element(make_item(32767, 32767, 1, 1'b0), pick_gap());
      send_element(make_item(-1, 1, 256, 1'b0), pick_gap());
      send_element(make_item(12345, -2345, 4660, 1'b1), pick_gap());
      send_element(make_item(100, -100, 0, 1'b1), pick_gap());

      write_mode(wed_pkg::MODE_EUCLIDEAN);
      send_element(make_item(32767, -32768, 65535, 1'b1), pick_gap());
      send_element(make_item(3, 0, 256, 1'b1), pick_gap());
      send_element(make_item(0, 0, 0, 1'b1), pick_gap());
      send_element(make_item(-32768, 0, 65535, 1'b0), pick_gap());
      send_element(make_item(0, 32767, 1, 1'b1), pick_gap());

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         write_mode((phase % 2) ? wed_pkg::MODE_EUCLIDEAN : wed_pkg::MODE_SQUARED);
         quiet      = ($urandom_range(0, 3) == 0);
         phase_len  = $urandom_range(100, 250);
         phase_sent = 0;
         while (phase_sent < phase_len) begin
            vector_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) :
                                                       $urandom_range(1, 8);
            for (int j = 0; j < vector_len; j++)
               send_element(make_item(random_value(), random_value(), random_weight(),
                                      j == vector_len - 1), pick_gap());
            phase_sent  += vector_len;
            random_sent += vector_len;
            if ($urandom_range(0, 29) == 0) idle_until_drained();
         end
         phase++;
      end

      idle_until_drained();
      $display("covered %0d element transfers, %0d vectors checked (%0d saturated)",
               elements_sent, board.results_checked, board.saturated_results);
      $display("both modes over %0d mode writes, zero and full weights, single-element vectors",
               mode_writes);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches, board.pending());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/wed_pkg.sv
rtl/core/wed_front.sv
rtl/core/wed_queue.sv
rtl/core/wed_back.sv
rtl/core/weighted_euclidean_distance.sv
bench/tb_top.sv
